// ===== design/isingm_pkg.sv =====
package isingm_pkg;

   localparam int MAX_SIDE = 64;
   localparam int MIN_SIDE = 2;
   localparam int COORD_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W   = COORD_W + 1;

   localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(MAX_SIDE - 1);

   // fixed field widths
   localparam int SITE_W     = 6;
   localparam int SIZE_W     = 7;
   localparam int DRAW_W     = 32;
   localparam int DE_W       = 5;
   localparam int ENERGY_W   = 15;
   localparam int MAG_W      = 14;
   localparam int COUNT_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LATTICE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_DE4   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_DE8   = 2'd2;

   // opcodes
   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_TRIAL = 1'b1;

   localparam int SIZE_RESET = 32;
   localparam logic [SIZE_W-1:0]   SIZE_RESET_VAL = SIZE_W'(SIZE_RESET);
   localparam logic [DRAW_W-1:0]   THRESH_DE4_RESET = 32'd78665070;
   localparam logic [DRAW_W-1:0]   THRESH_DE8_RESET = 32'd1440800;
   localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SIZE_RESET * SIZE_RESET);
   localparam logic [MAG_W-1:0]    MAG_RESET    = MAG_W'(SIZE_RESET * SIZE_RESET);

   localparam logic signed [DE_W-1:0] DE_FOUR  = 5'sd4;
   localparam logic [DE_W-1:0]        DE_EIGHT = 5'd8;
   localparam logic [MAG_W-1:0]       MAG_STEP = 14'd2;

   typedef struct packed {
      logic                     take;
      logic                     spin_old;
      logic signed [DE_W-1:0]   de;
      logic [MAX_SIDE-1:0]      row_new;
   } eval_result_type;

   // periodic neighbor coordinates
   function automatic logic [COORD_W-1:0] wrap_dec(input logic [COORD_W-1:0] c,
                                                   input logic [SIDE_W-1:0] n);
      if (c == '0) begin
         return COORD_W'(n - SIDE_W'(1));
      end
      return c - COORD_W'(1);
   endfunction

   function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] c,
                                                   input logic [SIDE_W-1:0] n);
      logic [SIDE_W-1:0] nxt;
      nxt = {1'b0, c} + SIDE_W'(1);
      if (nxt == n) begin
         return '0;
      end
      return COORD_W'(nxt);
   endfunction

endpackage

// ===== design/ising_metropolis_spin_update_core.sv =====
// Metropolis single-spin-flip engine for a 2D Ising lattice with periodic wrap.
// Command channel: a transaction is taken on a clock edge with start high and
// busy low. opcode clear sets every spin up and reloads energy, magnetization
// and flip count; opcode trial tests one site against the four neighbors.
// Result channel: rsp_valid strobes for one cycle with the result fields; the
// receiver cannot stall, so the result must be sampled in that cycle.
// Config: csr_we/csr_index/csr_data write lattice size and the two acceptance
// thresholds; write only while busy is low and no result is pending.
// Trial: an on-lattice trial holds busy high through three reads of the row
// memory's single read port (center row, row above, row below), then the
// evaluate/write-back state, which registers its result strobe.
// An off-lattice site answers the next cycle and busy stays low.
// A clear sweeps the 64-row memory one row a cycle with busy high; the result
// strobes the cycle after the sweep ends.
// Reset: synchronous, active high; control and config registers take their reset
// values and the same 64-row sweep runs (busy high, no result strobe).
module ising_metropolis_spin_update_core import isingm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_opcode,
   input  logic [SITE_W-1:0]          req_site_x,
   input  logic [SITE_W-1:0]          req_site_y,
   input  logic [DRAW_W-1:0]          req_uniform_draw,
   output logic                       rsp_valid,
   output logic                       rsp_flipped,
   output logic                       rsp_bad_site,
   output logic signed [DE_W-1:0]     rsp_energy_change,
   output logic signed [ENERGY_W-1:0] rsp_total_energy,
   output logic signed [MAG_W-1:0]    rsp_total_magnetization,
   output logic [COUNT_W-1:0]         rsp_accepted_total,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_RD_UP,
      ST_RD_DN,
      ST_EVAL
   } state_type;

   // config registers
   logic [SIZE_W-1:0] size_ff;
   logic [DRAW_W-1:0] thresh_de4_ff;
   logic [DRAW_W-1:0] thresh_de8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= SIZE_RESET_VAL;
         thresh_de4_ff <= THRESH_DE4_RESET;
         thresh_de8_ff <= THRESH_DE8_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LATTICE_SIZE: size_ff       <= csr_data[SIZE_W-1:0];
            CSR_THRESH_DE4:   thresh_de4_ff <= csr_data[DRAW_W-1:0];
            CSR_THRESH_DE8:   thresh_de8_ff <= csr_data[DRAW_W-1:0];
            default: ;
         endcase
      end
   end

   logic [SIDE_W-1:0]   n_use;
   logic [2*SIDE_W-1:0] n_sq;

   always_comb begin
      if (int'(size_ff) < MIN_SIDE) begin
         n_use = SIDE_W'(MIN_SIDE);
      end else if (int'(size_ff) > MAX_SIDE) begin
         n_use = SIDE_W'(MAX_SIDE);
      end else begin
         n_use = SIDE_W'(size_ff);
      end
   end

   assign n_sq = n_use * n_use;

   state_type                state_ff, state_in;
   logic [COORD_W-1:0]       row_cnt_ff, row_cnt_in;
   logic                     clear_rsp_ff, clear_rsp_in;
   logic [COORD_W-1:0]       x_ff, x_in;
   logic [COORD_W-1:0]       y_ff, y_in;
   logic [DRAW_W-1:0]        draw_ff, draw_in;
   logic [MAX_SIDE-1:0]      mid_ff, mid_in;
   logic [MAX_SIDE-1:0]      up_ff, up_in;
   logic [ENERGY_W-1:0]      energy_ff, energy_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_flipped_ff, rsp_flipped_in;
   logic                     rsp_bad_ff, rsp_bad_in;
   logic [DE_W-1:0]          rsp_de_ff, rsp_de_in;
   logic [ENERGY_W-1:0]      rsp_energy_ff, rsp_energy_in;
   logic [MAG_W-1:0]         rsp_mag_ff, rsp_mag_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic                     ram_we;
   logic [COORD_W-1:0]       ram_waddr;
   logic [MAX_SIDE-1:0]      ram_wdata;
   logic [COORD_W-1:0]       ram_raddr;
   logic [MAX_SIDE-1:0]      ram_rdata;
   eval_result_type          eval_res;
   logic                     accept;
   logic                     site_bad;

   assign accept   = start && (state_ff == ST_IDLE);
   assign site_bad = (SIDE_W'(req_site_x) >= n_use) || (SIDE_W'(req_site_y) >= n_use);

   isingm_ram #(
      .WIDTH (MAX_SIDE),
      .DEPTH (MAX_SIDE)
   ) u_lattice (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   isingm_eval u_eval (
      .row_mid    (mid_ff),
      .row_up     (up_ff),
      .row_dn     (ram_rdata),
      .x          (x_ff),
      .n          (n_use),
      .draw       (draw_ff),
      .thresh_de4 (thresh_de4_ff),
      .thresh_de8 (thresh_de8_ff),
      .result     (eval_res)
   );

   // memory port: read data is registered, so the read address is presented the cycle before its data
   always_comb begin
      unique case (state_ff)
         ST_IDLE:  ram_raddr = COORD_W'(req_site_y);
         ST_RD_UP: ram_raddr = wrap_dec(y_ff, n_use);
         ST_RD_DN: ram_raddr = wrap_inc(y_ff, n_use);
         default:  ram_raddr = y_ff;
      endcase
      ram_we    = 1'b0;
      ram_waddr = y_ff;
      ram_wdata = eval_res.row_new;
      if (state_ff == ST_SWEEP) begin
         ram_we    = 1'b1;
         ram_waddr = row_cnt_ff;
         ram_wdata = '1;
      end else if (state_ff == ST_EVAL) begin
         ram_we = eval_res.take;
      end
   end

   always_comb begin
      state_in       = state_ff;
      row_cnt_in     = row_cnt_ff;
      clear_rsp_in   = clear_rsp_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      draw_in        = draw_ff;
      mid_in         = mid_ff;
      up_in          = up_ff;
      energy_in      = energy_ff;
      mag_in         = mag_ff;
      count_in       = count_ff;
      rsp_valid_in   = 1'b0;
      rsp_flipped_in = 1'b0;
      rsp_bad_in     = 1'b0;
      rsp_de_in      = '0;
      rsp_energy_in  = energy_ff;
      rsp_mag_in     = mag_ff;
      rsp_count_in   = count_ff;

      unique case (state_ff)
         ST_SWEEP: begin
            row_cnt_in = row_cnt_ff + COORD_W'(1);
            if (row_cnt_ff == LAST_ROW) begin
               state_in     = ST_IDLE;
               clear_rsp_in = 1'b0;
               rsp_valid_in = clear_rsp_ff;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_CLEAR) begin
                  state_in     = ST_SWEEP;
                  row_cnt_in   = '0;
                  clear_rsp_in = 1'b1;
                  energy_in    = ENERGY_W'(0) - ENERGY_W'({n_sq, 1'b0});
                  mag_in       = MAG_W'(n_sq);
                  count_in     = '0;
               end else begin
                  x_in    = COORD_W'(req_site_x);
                  y_in    = COORD_W'(req_site_y);
                  draw_in = req_uniform_draw;
                  if (site_bad) begin
                     rsp_valid_in = 1'b1;
                     rsp_bad_in   = 1'b1;
                  end else begin
                     state_in = ST_RD_UP;
                  end
               end
            end
         end
         ST_RD_UP: begin
            mid_in   = ram_rdata;
            state_in = ST_RD_DN;
         end
         ST_RD_DN: begin
            up_in    = ram_rdata;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (eval_res.take) begin
               energy_in = energy_ff + {{(ENERGY_W-DE_W){eval_res.de[DE_W-1]}}, eval_res.de};
               mag_in    = eval_res.spin_old ? (mag_ff - MAG_STEP) : (mag_ff + MAG_STEP);
               count_in  = (count_ff != '1) ? (count_ff + COUNT_W'(1)) : count_ff;
            end
            rsp_valid_in   = 1'b1;
            rsp_flipped_in = eval_res.take;
            rsp_de_in      = eval_res.de;
            rsp_energy_in  = energy_in;
            rsp_mag_in     = mag_in;
            rsp_count_in   = count_in;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         row_cnt_ff   <= '0;
         clear_rsp_ff <= 1'b0;
         energy_ff    <= ENERGY_RESET;
         mag_ff       <= MAG_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         clear_rsp_ff <= clear_rsp_in;
         energy_ff    <= energy_in;
         mag_ff       <= mag_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff           <= x_in;
      y_ff           <= y_in;
      draw_ff        <= draw_in;
      mid_ff         <= mid_in;
      up_ff          <= up_in;
      rsp_flipped_ff <= rsp_flipped_in;
      rsp_bad_ff     <= rsp_bad_in;
      rsp_de_ff      <= rsp_de_in;
      rsp_energy_ff  <= rsp_energy_in;
      rsp_mag_ff     <= rsp_mag_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign busy                    = (state_ff != ST_IDLE);
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_flipped             = rsp_flipped_ff;
   assign rsp_bad_site            = rsp_bad_ff;
   assign rsp_energy_change       = $signed(rsp_de_ff);
   assign rsp_total_energy        = $signed(rsp_energy_ff);
   assign rsp_total_magnetization = $signed(rsp_mag_ff);
   assign rsp_accepted_total      = rsp_count_ff;

`ifndef NO_ASSERTIONS
   // results only come out once the engine has returned to idle
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // an on-lattice trial answers after the three reads and the evaluate cycle
   a_trial_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_TRIAL) && !site_bad) |-> ##4 (rsp_valid && !rsp_bad_site))
      else $error("trial result missing or late");

   // an off-lattice trial answers at once, flagged and without a flip
   a_bad_site: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_TRIAL) && site_bad) |=>
         (rsp_valid && rsp_bad_site && !rsp_flipped && !busy))
      else $error("bad site not reported");
`endif

endmodule

// ===== design/isingm_ram.sv =====
module isingm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/isingm_eval.sv =====
module isingm_eval import isingm_pkg::*; (
   input  logic [MAX_SIDE-1:0] row_mid,
   input  logic [MAX_SIDE-1:0] row_up,
   input  logic [MAX_SIDE-1:0] row_dn,
   input  logic [COORD_W-1:0]  x,
   input  logic [SIDE_W-1:0]   n,
   input  logic [DRAW_W-1:0]   draw,
   input  logic [DRAW_W-1:0]   thresh_de4,
   input  logic [DRAW_W-1:0]   thresh_de8,
   output eval_result_type     result
);

   logic [COORD_W-1:0] xl;
   logic [COORD_W-1:0] xr;
   logic [2:0]         up_cnt;
   logic [DE_W-1:0]    de_up;
   logic signed [DE_W-1:0] de;
   logic               spin;

   assign xl   = wrap_dec(x, n);
   assign xr   = wrap_inc(x, n);
   assign spin = row_mid[x];

   // neighbors up: sum = 2*cnt - 4, dE = +/-(4*cnt - 8)
   assign up_cnt = 3'(row_up[x]) + 3'(row_dn[x]) + 3'(row_mid[xl]) + 3'(row_mid[xr]);
   assign de_up  = {up_cnt[2:0], 2'b00} - DE_EIGHT;
   assign de     = spin ? $signed(de_up) : $signed(DE_W'(0) - de_up);

   always_comb begin
      result.spin_old = spin;
      result.de       = de;
      result.row_new  = row_mid;
      result.row_new[x] = ~spin;
      if (de[DE_W-1] || (de == '0)) begin
         result.take = 1'b1;
      end else if (de == DE_FOUR) begin
         result.take = (draw <= thresh_de4);
      end else begin
         result.take = (draw <= thresh_de8);
      end
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import isingm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PRINT_LIMIT    = 40;
   localparam int QUIET_FROM     = 800;
   localparam int QUIET_TO       = 1200;
   localparam int NUM_DIRECTED   = 20;
   localparam int NUM_PHASES     = 11;

   typedef struct packed {
      logic                       flipped;
      logic                       bad_site;
      logic signed [DE_W-1:0]     energy_change;
      logic signed [ENERGY_W-1:0] total_energy;
      logic signed [MAG_W-1:0]    total_magnetization;
      logic [COUNT_W-1:0]         accepted_total;
   } spin_result_type;

   typedef struct packed {
      logic              opcode;
      logic [SITE_W-1:0] site_x;
      logic [SITE_W-1:0] site_y;
      logic [DRAW_W-1:0] draw;
      logic              typed;
      spin_result_type   result;
   } directed_row_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] size_word;
      logic [DRAW_W-1:0]     thresh4;
      logic [DRAW_W-1:0]     thresh8;
      logic                  clear_first;
      logic                  random_thresh;
      logic [15:0]           items;
   } phase_type;

   // rows with typed results hold for the reset configuration (L = 32)
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{OP_TRIAL, 6'd0,  6'd0,  32'd0,
        1'b1, '{1'b1, 1'b0, 5'sd8, -15'sd2040, 14'sd1022, 32'd1}},
      '{OP_TRIAL, 6'd0,  6'd0,  32'hFFFF_FFFF,
        1'b1, '{1'b1, 1'b0, -5'sd8, -15'sd2048, 14'sd1024, 32'd2}},
      '{OP_TRIAL, 6'd32, 6'd5,  32'd0,
        1'b1, '{1'b0, 1'b1, 5'sd0, -15'sd2048, 14'sd1024, 32'd2}},
      '{OP_TRIAL, 6'd7,  6'd63, 32'd0,
        1'b1, '{1'b0, 1'b1, 5'sd0, -15'sd2048, 14'sd1024, 32'd2}},
      '{OP_TRIAL, 6'd63, 6'd63, 32'hFFFF_FFFF,
        1'b1, '{1'b0, 1'b1, 5'sd0, -15'sd2048, 14'sd1024, 32'd2}},
      '{OP_TRIAL, 6'd31, 6'd31, 32'hFFFF_FFFF,
        1'b1, '{1'b0, 1'b0, 5'sd8, -15'sd2048, 14'sd1024, 32'd2}},
      '{OP_TRIAL, 6'd31, 6'd31, 32'd1440800,
        1'b1, '{1'b1, 1'b0, 5'sd8, -15'sd2040, 14'sd1022, 32'd3}},
      // neighbor across the x wrap is down: dE = 4, one above / at threshold
      '{OP_TRIAL, 6'd0,  6'd31, 32'd78665071, 1'b0, '0},
      '{OP_TRIAL, 6'd0,  6'd31, 32'd78665070, 1'b0, '0},
      '{OP_TRIAL, 6'd31, 6'd0,  32'd0,        1'b0, '0},
      '{OP_TRIAL, 6'd10, 6'd10, 32'd0,        1'b0, '0},
      '{OP_TRIAL, 6'd12, 6'd10, 32'd0,        1'b0, '0},
      // two down neighbors: dE = 0 both ways
      '{OP_TRIAL, 6'd11, 6'd10, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_TRIAL, 6'd11, 6'd10, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_TRIAL, 6'd0,  6'd31, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_CLEAR, 6'd63, 6'd63, 32'hFFFF_FFFF,
        1'b1, '{1'b0, 1'b0, 5'sd0, -15'sd2048, 14'sd1024, 32'd0}},
      '{OP_CLEAR, 6'd0,  6'd0,  32'd0,
        1'b1, '{1'b0, 1'b0, 5'sd0, -15'sd2048, 14'sd1024, 32'd0}},
      '{OP_TRIAL, 6'd31, 6'd0,  32'hFFFF_FFFF,
        1'b1, '{1'b0, 1'b0, 5'sd8, -15'sd2048, 14'sd1024, 32'd0}},
      '{OP_TRIAL, 6'd0,  6'd32, 32'd0,
        1'b1, '{1'b0, 1'b1, 5'sd0, -15'sd2048, 14'sd1024, 32'd0}},
      '{OP_TRIAL, 6'd42, 6'd21, 32'h5A5A_5A5A, 1'b0, '0}
   };

   // size values below 2 or above 64 clamp; 0xFFFFFF91 keeps only 7 bits (17)
   localparam phase_type PHASES [NUM_PHASES] = '{
      '{32'd2,          32'h8000_0000, 32'h4000_0000, 1'b1, 1'b0, 16'd180},
      '{32'd64,         32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'd180},
      '{32'd0,          32'd0,         32'd0,         1'b1, 1'b0, 16'd160},
      '{32'd127,        32'd0,         32'd0,         1'b1, 1'b1, 16'd200},
      '{32'd5,          32'd0,         32'd0,         1'b0, 1'b1, 16'd160},
      '{32'd1,          32'h2000_0000, 32'h0100_0000, 1'b1, 1'b0, 16'd160},
      '{32'd65,         32'h0400_0000, 32'h0010_0000, 1'b0, 1'b0, 16'd200},
      '{32'hFFFF_FF91,  32'h1234_5678, 32'h00AB_CDEF, 1'b0, 1'b0, 16'd180},
      '{32'd48,         32'd0,         32'd0,         1'b1, 1'b1, 16'd200},
      '{32'd3,          32'd0,         32'd0,         1'b1, 1'b1, 16'd160},
      '{32'd32, THRESH_DE4_RESET, THRESH_DE8_RESET,   1'b1, 1'b0, 16'd180}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_opcode = OP_CLEAR;
   logic [SITE_W-1:0]          req_site_x = '0;
   logic [SITE_W-1:0]          req_site_y = '0;
   logic [DRAW_W-1:0]          req_uniform_draw = '0;
   logic                       rsp_valid;
   logic                       rsp_flipped;
   logic                       rsp_bad_site;
   logic signed [DE_W-1:0]     rsp_energy_change;
   logic signed [ENERGY_W-1:0] rsp_total_energy;
   logic signed [MAG_W-1:0]    rsp_total_magnetization;
   logic [COUNT_W-1:0]         rsp_accepted_total;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = CSR_LATTICE_SIZE;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // typed expectation travels alongside the transaction it belongs to
   logic                       typed_valid = 1'b0;
   spin_result_type            typed_result = '0;

   // lattice predictor state
   bit                         spin_up [MAX_SIDE*MAX_SIDE];
   logic signed [ENERGY_W-1:0] energy_now;
   logic signed [MAG_W-1:0]    magnet_now;
   logic [COUNT_W-1:0]         flips_now;
   logic [SIZE_W-1:0]          side_reg;
   logic [DRAW_W-1:0]          thresh4_reg;
   logic [DRAW_W-1:0]          thresh8_reg;
   spin_result_type            pending_q [$];

   int mismatch_count = 0;
   int results_seen   = 0;
   int flips_seen     = 0;
   int bad_seen       = 0;
   int clears_seen    = 0;
   int items_sent     = 0;
   int stall_cycles   = 0;

   ising_metropolis_spin_update_core DUT (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_opcode              (req_opcode),
      .req_site_x              (req_site_x),
      .req_site_y              (req_site_y),
      .req_uniform_draw        (req_uniform_draw),
      .rsp_valid               (rsp_valid),
      .rsp_flipped             (rsp_flipped),
      .rsp_bad_site            (rsp_bad_site),
      .rsp_energy_change       (rsp_energy_change),
      .rsp_total_energy        (rsp_total_energy),
      .rsp_total_magnetization (rsp_total_magnetization),
      .rsp_accepted_total      (rsp_accepted_total),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int side_in_use(input logic [SIZE_W-1:0] sz);
      if (sz < MIN_SIDE) return MIN_SIDE;
      if (sz > MAX_SIDE) return MAX_SIDE;
      return int'(sz);
   endfunction

   function automatic int spin_of(input int x, input int y);
      return spin_up[y*MAX_SIDE + x] ? 1 : -1;
   endfunction

   function automatic void reload_lattice();
      int n;
      n = side_in_use(side_reg);
      foreach (spin_up[i]) spin_up[i] = 1'b1;
      energy_now = ENERGY_W'(-2 * n * n);
      magnet_now = MAG_W'(n * n);
      flips_now  = '0;
   endfunction

   function automatic spin_result_type metropolis_step(input logic op,
                                                      input logic [SITE_W-1:0] x,
                                                      input logic [SITE_W-1:0] y,
                                                      input logic [DRAW_W-1:0] draw);
      spin_result_type r;
      int n, xi, yi, s, nsum, de;
      logic take;
      r = '0;
      if (op == OP_CLEAR) begin
         reload_lattice();
      end else begin
         n  = side_in_use(side_reg);
         xi = int'(x);
         yi = int'(y);
         if (xi >= n || yi >= n) begin
            r.bad_site = 1'b1;
         end else begin
            s    = spin_of(xi, yi);
            nsum = spin_of((xi + n - 1) % n, yi) + spin_of((xi + 1) % n, yi)
                 + spin_of(xi, (yi + n - 1) % n) + spin_of(xi, (yi + 1) % n);
            de   = 2 * s * nsum;
            if (de <= 0) begin
               take = 1'b1;
            end else if (de == 4) begin
               take = (draw <= thresh4_reg);
            end else begin
               take = (draw <= thresh8_reg);
            end
            r.energy_change = DE_W'(de);
            if (take) begin
               spin_up[yi*MAX_SIDE + xi] = (s < 0);
               magnet_now = magnet_now + MAG_W'(-2 * s);
               energy_now = energy_now + ENERGY_W'(de);
               if (flips_now != '1) flips_now = flips_now + 1'b1;
               r.flipped = 1'b1;
            end
         end
      end
      r.total_energy        = energy_now;
      r.total_magnetization = magnet_now;
      r.accepted_total      = flips_now;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("[%0t] ERROR %s", $time, msg);
   endtask

   task automatic check_field(input string field, input longint got, input longint want);
      if (got != want) begin
         report_mismatch($sformatf("result %0d %s: got %0d expected %0d",
                                   results_seen, field, got, want));
      end
   endtask

   // scoreboard: compare strobed results, track CSR writes, predict accepted transactions
   always @(posedge clock) begin
      spin_result_type want;
      if (reset) begin
         side_reg    = SIZE_RESET_VAL;
         thresh4_reg = THRESH_DE4_RESET;
         thresh8_reg = THRESH_DE8_RESET;
         reload_lattice();
         pending_q.delete();
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (rsp_flipped) flips_seen++;
            if (rsp_bad_site) bad_seen++;
            if (pending_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing pending",
                                         results_seen));
            end else begin
               want = pending_q.pop_front();
               check_field("flipped", longint'(rsp_flipped), longint'(want.flipped));
               check_field("bad_site", longint'(rsp_bad_site), longint'(want.bad_site));
               check_field("energy_change", longint'(rsp_energy_change),
                           longint'($signed(want.energy_change)));
               check_field("total_energy", longint'(rsp_total_energy),
                           longint'($signed(want.total_energy)));
               check_field("total_magnetization", longint'(rsp_total_magnetization),
                           longint'($signed(want.total_magnetization)));
               check_field("accepted_total", longint'(rsp_accepted_total),
                           longint'(want.accepted_total));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_LATTICE_SIZE: side_reg    = csr_data[SIZE_W-1:0];
               CSR_THRESH_DE4:   thresh4_reg = csr_data[DRAW_W-1:0];
               CSR_THRESH_DE8:   thresh8_reg = csr_data[DRAW_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_opcode == OP_CLEAR) clears_seen++;
            want = metropolis_step(req_opcode, req_site_x, req_site_y, req_uniform_draw);
            if (typed_valid) want = typed_result;
            pending_q.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || csr_we || reset) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] timeout: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_item(input logic op, input logic [SITE_W-1:0] x,
                            input logic [SITE_W-1:0] y, input logic [DRAW_W-1:0] draw,
                            input logic typed, input spin_result_type result);
      if ((items_sent < QUIET_FROM || items_sent >= QUIET_TO) &&
          $urandom_range(0, 99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start            <= 1'b1;
      req_opcode       <= op;
      req_site_x       <= x;
      req_site_y       <= y;
      req_uniform_draw <= draw;
      typed_valid      <= typed;
      typed_result     <= result;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // block idle: nothing pending, busy low, plus a margin for the pipeline
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      phase_type         ph;
      int                n, pick;
      logic              op;
      logic [SITE_W-1:0] x, y;
      logic [DRAW_W-1:0] draw, t4, t8;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         send_item(DIRECTED_ROWS[i].opcode, DIRECTED_ROWS[i].site_x, DIRECTED_ROWS[i].site_y,
                   DIRECTED_ROWS[i].draw, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
      end

      foreach (PHASES[p]) begin
         ph = PHASES[p];
         settle();
         t4 = ph.random_thresh ? DRAW_W'($urandom) : ph.thresh4;
         t8 = ph.random_thresh ? DRAW_W'($urandom) : ph.thresh8;
         csr_write(CSR_LATTICE_SIZE, ph.size_word);
         csr_write(CSR_THRESH_DE4, t4);
         csr_write(CSR_THRESH_DE8, t8);
         if (ph.clear_first) begin
            send_item(OP_CLEAR, SITE_W'($urandom), SITE_W'($urandom), DRAW_W'($urandom),
                      1'b0, '0);
         end
         for (int k = 0; k < int'(ph.items); k++) begin
            n    = side_in_use(side_reg);
            pick = $urandom_range(0, 99);
            op   = OP_TRIAL;
            x    = SITE_W'($urandom_range(0, n - 1));
            y    = SITE_W'($urandom_range(0, n - 1));
            if (pick < 2) begin
               op = OP_CLEAR;
               x  = SITE_W'($urandom);
               y  = SITE_W'($urandom);
            end else if (pick < 10 && n < MAX_SIDE) begin
               case ($urandom_range(0, 2))
                  0: x = SITE_W'($urandom_range(n, MAX_SIDE - 1));
                  1: y = SITE_W'($urandom_range(n, MAX_SIDE - 1));
                  default: begin
                     x = SITE_W'($urandom_range(n, MAX_SIDE - 1));
                     y = SITE_W'($urandom_range(n, MAX_SIDE - 1));
                  end
               endcase
            end
            // bias draws around the acceptance limits
            case ($urandom_range(0, 9))
               0:       draw = '0;
               1:       draw = '1;
               2, 3, 4: draw = thresh4_reg + DRAW_W'($urandom_range(0, 4)) - DRAW_W'(2);
               5, 6, 7: draw = thresh8_reg + DRAW_W'($urandom_range(0, 4)) - DRAW_W'(2);
               default: draw = DRAW_W'($urandom);
            endcase
            send_item(op, x, y, draw, 1'b0, '0);
         end
      end

      settle();
      $display("Sent %0d transactions (%0d directed) across %0d lattice settings, sizes 2..64.",
               items_sent, NUM_DIRECTED, NUM_PHASES + 1);
      $display("Checked %0d results: %0d flips, %0d off-lattice, %0d clears; %0d mismatches.",
               results_seen, flips_seen, bad_seen, clears_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/isingm_pkg.sv
design/isingm_ram.sv
design/isingm_eval.sv
design/ising_metropolis_spin_update_core.sv
test/tb_top.sv
